### design/mkss_pkg.sv
// ----------------------------------------------------------------------------
// mkss_pkg
// types and constants shared by the k-means seed sampler
// ----------------------------------------------------------------------------
package mkss_pkg;

   localparam int MAX_POINTS  = 4096;
   localparam int MAX_DIMS    = 64;
   localparam int MAX_CENTERS = 256;
   localparam int COORD_BITS  = 16;

   localparam int PT_BITS    = $clog2(MAX_POINTS);
   localparam int DIM_BITS   = $clog2(MAX_DIMS);
   localparam int CEN_BITS   = $clog2(MAX_CENTERS);
   localparam int DIST_BITS  = 38;
   localparam int W_BITS     = 32;
   localparam int MA_BITS    = DIST_BITS + W_BITS;
   localparam int MP_BITS    = MA_BITS + W_BITS;
   localparam int MCNT_BITS  = $clog2(W_BITS);

   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

   typedef enum logic [1:0] {
      REQ_WRITE_COORD = 2'd0,
      REQ_APPEND      = 2'd1,
      REQ_CLEAR       = 2'd2,
      REQ_CANDIDATE   = 2'd3
   } req_kind_type;

   typedef enum logic [0:0] {
      CSR_DIMS  = 1'b0,
      CSR_CHAIN = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CEN, S_DIM, S_DRAIN,
      S_M1, S_M1W, S_M2, S_M2W, S_M3, S_M3W, S_DEC
   } state_type;

endpackage

### design/mkss_smul.sv
// ----------------------------------------------------------------------------
// mkss_smul
// shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module mkss_smul
   import mkss_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MA_BITS-1:0] mcand,
   input  logic [W_BITS-1:0]  mplier,
   output logic               done,
   output logic [MP_BITS-1:0] product
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MCNT_BITS-1:0] cnt_ff, cnt_in;
   logic [MP_BITS-1:0]   acc_ff, acc_in;
   logic [MP_BITS-1:0]   mc_ff, mc_in;
   logic [W_BITS-1:0]    mp_ff, mp_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         mc_in   = {{(MP_BITS-MA_BITS){1'b0}}, mcand};
         mp_in   = mplier;
      end else if (busy_ff) begin
         if (mp_ff[0]) begin
            acc_in = acc_ff + mc_ff;
         end
         mc_in  = {mc_ff[MP_BITS-2:0], 1'b0};
         mp_in  = {1'b0, mp_ff[W_BITS-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MCNT_BITS'(W_BITS-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

`ifndef ASSERT_OFF
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("multiplier restarted while busy");
   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");
   a_done_after: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without work");
`endif

endmodule

### design/mcmc_kmeans_seed_sampler.sv
// ----------------------------------------------------------------------------
// mcmc_kmeans_seed_sampler
// metropolis-hastings chain step for k-means seeding over a stored point set
//
//  channel  dir  handshake           payload
//  req      in   req_tvalid/tready   tuser kind, tdata point/dim/coord/q/u
//  rsp      out  rsp_tvalid/tready   tdata index/dist, tuser accepted, tlast
//  csr      in   csr_we              csr_index, csr_wdata
//
//  load beats are accepted only while no candidate is in progress
//  a candidate walks each center through its dimensions, one coordinate pair
//  read per cycle, then runs three multiplies; the first-step, zero-distance
//  or zero-weight shortcut skips the three multiplies
//  reset is synchronous; stores start unwritten, chain starts fresh
//  a pending result stalls only the final decision step
// ----------------------------------------------------------------------------
module mcmc_kmeans_seed_sampler
   import mkss_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // req_type
   input  logic [103:0] req_tdata,   // point_index, dim_index, coord_value,
                                     // proposal_weight, uniform_draw
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [55:0]  rsp_tdata,   // chosen_index, chosen_dist
   output logic         rsp_tuser,   // accepted
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [9:0]   csr_wdata
);

   state_type state_ff, state_in;

   logic [PT_BITS-1:0]          f_pt;
   logic [DIM_BITS-1:0]         f_dim;
   logic signed [COORD_BITS-1:0] f_coord;
   logic [W_BITS-1:0]           f_qy, f_u;
   req_kind_type                f_kind;

   assign f_kind  = req_kind_type'(req_tuser);
   assign f_pt    = req_tdata[11:0];
   assign f_dim   = req_tdata[17:12];
   assign f_coord = req_tdata[33:18];
   assign f_qy    = req_tdata[65:34];
   assign f_u     = req_tdata[97:66];

   logic [6:0]  dims_ff;
   logic [9:0]  chain_ff;
   logic [CEN_BITS:0] count_ff;
   logic [PT_BITS-1:0] cur_idx_ff;
   logic [DIST_BITS-1:0] cur_dist_ff;
   logic [W_BITS-1:0] cur_w_ff;
   logic [9:0]  step_ff;

   logic [PT_BITS-1:0] pt_ff;
   logic [W_BITS-1:0]  qy_ff, u_ff;
   logic               fast_ff;
   logic [DIST_BITS-1:0] best_ff;
   logic [DIST_BITS:0]   acc_ff;
   logic [CEN_BITS:0]    c_ff;
   logic [DIM_BITS:0]    d_ff;
   logic                 rd_vld_ff, sq_vld_ff;
   logic [2*COORD_BITS+1:0] sq_ff;
   logic [MA_BITS-1:0]   lhs_ff, r1_ff;
   logic [MP_BITS-1:0]   rhs_ff;

   logic         rsp_valid_ff;
   logic [PT_BITS-1:0]   rsp_idx_ff;
   logic [DIST_BITS-1:0] rsp_dist_ff;
   logic         rsp_acc_ff, rsp_last_ff;

   // memories
   logic [COORD_BITS-1:0] pmem [MAX_POINTS*MAX_DIMS];
   logic [PT_BITS-1:0]    cmem [MAX_CENTERS];
   logic [COORD_BITS-1:0] pa_ff, pb_ff;
   logic [PT_BITS-1:0]    cl_ff;

   logic accept, issue, pipe_empty, mul_start, mul_done;
   logic [DIM_BITS:0] dlim;
   logic [MA_BITS-1:0] mul_a;
   logic [W_BITS-1:0]  mul_b;
   logic [MP_BITS-1:0] mul_p;

   assign accept     = req_tvalid && req_tready;
   assign dlim       = (dims_ff > 7'(MAX_DIMS)) ? (DIM_BITS+1)'(MAX_DIMS)
                                                : (DIM_BITS+1)'(dims_ff);
   assign issue      = (state_ff == S_DIM) && (d_ff < dlim);
   assign pipe_empty = !rd_vld_ff && !sq_vld_ff;

   always_ff @(posedge clock) begin
      if (accept && f_kind == REQ_WRITE_COORD) begin
         pmem[{f_pt, f_dim}] <= f_coord;
      end
      pa_ff <= pmem[{pt_ff, d_ff[DIM_BITS-1:0]}];
      pb_ff <= pmem[{cl_ff, d_ff[DIM_BITS-1:0]}];
   end

   always_ff @(posedge clock) begin
      if (accept && f_kind == REQ_APPEND && count_ff < (CEN_BITS+1)'(MAX_CENTERS)) begin
         cmem[count_ff[CEN_BITS-1:0]] <= f_pt;
      end
      cl_ff <= cmem[c_ff[CEN_BITS-1:0]];
   end

   // squared difference
   logic signed [COORD_BITS:0] diff;
   logic [COORD_BITS:0]        mag;
   assign diff = $signed({pa_ff[COORD_BITS-1], pa_ff})
               - $signed({pb_ff[COORD_BITS-1], pb_ff});
   assign mag  = diff[COORD_BITS] ? (COORD_BITS+1)'(-diff) : diff;

   logic [DIST_BITS-1:0] sat;
   assign sat = (acc_ff > {1'b0, DIST_MAX}) ? DIST_MAX : acc_ff[DIST_BITS-1:0];

   logic take;
   assign take = fast_ff || ({lhs_ff, {W_BITS{1'b0}}} > rhs_ff);

   logic [10:0] step_nx;
   logic [9:0]  limit;
   logic        last;
   assign limit   = (chain_ff == 10'd0) ? 10'd1 : chain_ff;
   assign step_nx = {1'b0, step_ff} + 11'd1;
   assign last    = step_nx >= {1'b0, limit};

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      mul_start  = 1'b0;
      mul_a      = {{(MA_BITS-DIST_BITS){1'b0}}, best_ff};
      mul_b      = cur_w_ff;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && f_kind == REQ_CANDIDATE) begin
               state_in = (count_ff == '0) ? S_M1 : S_CEN;
            end
         end
         S_CEN: state_in = S_DIM;
         S_DIM: if (d_ff >= dlim) state_in = S_DRAIN;
         S_DRAIN: begin
            if (pipe_empty) begin
               state_in = (c_ff + 1'b1 >= count_ff) ? S_M1 : S_CEN;
            end
         end
         S_M1: begin
            if (fast_ff) begin
               state_in = S_DEC;
            end else begin
               mul_start = 1'b1;
               state_in  = S_M1W;
            end
         end
         S_M1W: if (mul_done) state_in = S_M2;
         S_M2: begin
            mul_start = 1'b1;
            mul_a     = {{(MA_BITS-DIST_BITS){1'b0}}, cur_dist_ff};
            mul_b     = qy_ff;
            state_in  = S_M2W;
         end
         S_M2W: if (mul_done) state_in = S_M3;
         S_M3: begin
            mul_start = 1'b1;
            mul_a     = r1_ff;
            mul_b     = u_ff;
            state_in  = S_M3W;
         end
         S_M3W: if (mul_done) state_in = S_DEC;
         S_DEC: if (!rsp_valid_ff) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   mkss_smul u_smul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_a),
      .mplier  (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dims_ff      <= 7'd1;
         chain_ff     <= 10'd200;
         count_ff     <= '0;
         cur_idx_ff   <= '0;
         cur_dist_ff  <= '0;
         cur_w_ff     <= '0;
         step_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         sq_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= issue;
         sq_vld_ff <= rd_vld_ff;
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_DIMS:  dims_ff  <= csr_wdata[6:0];
               CSR_CHAIN: chain_ff <= csr_wdata;
               default:   ;
            endcase
         end
         if (accept) begin
            case (f_kind)
               REQ_APPEND: begin
                  if (count_ff < (CEN_BITS+1)'(MAX_CENTERS)) begin
                     count_ff <= count_ff + 1'b1;
                     step_ff  <= '0;
                  end
               end
               REQ_CLEAR: begin
                  count_ff <= '0;
                  step_ff  <= '0;
               end
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == S_DEC && !rsp_valid_ff) begin
            if (take) begin
               cur_idx_ff  <= pt_ff;
               cur_dist_ff <= best_ff;
               cur_w_ff    <= qy_ff;
            end
            step_ff      <= last ? 10'd0 : step_nx[9:0];
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      sq_ff <= mag * mag;
      if (accept && f_kind == REQ_CANDIDATE) begin
         pt_ff   <= f_pt;
         qy_ff   <= f_qy;
         u_ff    <= f_u;
         fast_ff <= (step_ff == '0) || (cur_dist_ff == '0) || (f_qy == '0);
         best_ff <= DIST_MAX;
         c_ff    <= '0;
      end
      if (state_ff == S_CEN) begin
         acc_ff <= '0;
         d_ff   <= '0;
      end else if (sq_vld_ff) begin
         acc_ff <= acc_ff + (DIST_BITS+1)'(sq_ff);
      end
      if (issue) begin
         d_ff <= d_ff + 1'b1;
      end
      if (state_ff == S_DRAIN && pipe_empty) begin
         if (sat < best_ff) begin
            best_ff <= sat;
         end
         c_ff <= c_ff + 1'b1;
      end
      if (state_ff == S_M1W && mul_done) lhs_ff <= mul_p[MA_BITS-1:0];
      if (state_ff == S_M2W && mul_done) r1_ff  <= mul_p[MA_BITS-1:0];
      if (state_ff == S_M3W && mul_done) rhs_ff <= mul_p;
      if (state_ff == S_DEC && !rsp_valid_ff) begin
         rsp_idx_ff  <= take ? pt_ff : cur_idx_ff;
         rsp_dist_ff <= take ? best_ff : cur_dist_ff;
         rsp_acc_ff  <= take;
         rsp_last_ff <= last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_dist_ff, rsp_idx_ff};
   assign rsp_tuser  = rsp_acc_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (CEN_BITS+1)'(MAX_CENTERS)) else $error("center count overflow");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("ready while busy");
   a_dec_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEC && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("decision lost");
   a_pipe_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !sq_vld_ff) else $error("distance work in idle");
`endif

endmodule

### dv/tb_mcmc_kmeans_seed_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mcmc_kmeans_seed_sampler
// checks the seed sampler chain step against a cycle-free model of the chain
//
// a fixed pool of points gets its first few coordinates written up front and
// distances with centers never use more, so no unwritten entry is ever read.
// Directed beats then cover the extreme values, the empty center list, zero
// and clamped dimension counts, zero weights and a shortened chain. Random
// beats follow over several register settings. The sender runs in bursts and
// the receiver stalls on its own pattern. Every result beat is compared field
// by field with the model.
// ----------------------------------------------------------------------------
module tb_mcmc_kmeans_seed_sampler;
   import mkss_pkg::*;

   typedef struct {
      req_kind_type       kind;
      logic [11:0]        pt;
      logic [5:0]         dim;
      logic signed [15:0] coord;
      logic [31:0]        q;
      logic [31:0]        u;
   } load_beat_type;

   typedef struct {
      logic [11:0] idx;
      logic [37:0] dsq;
      logic        acc;
      logic        last;
   } pick_type;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int FILL_DIMS   = 6;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [1:0]   req_tuser;
   logic [103:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [55:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we;
   logic         csr_index;
   logic [9:0]   csr_wdata;

   mcmc_kmeans_seed_sampler DUT (.*);

   // model state
   logic signed [15:0] coord_mem [0:4095][0:63];
   logic [11:0]        center_pts [0:255];
   int                 n_centers;
   logic [11:0]        chain_idx;
   logic [37:0]        chain_dist;
   logic [31:0]        chain_q;
   int                 chain_steps;
   logic [6:0]         dims_reg;
   logic [9:0]         chain_len_reg;

   load_beat_type beat_q [$];
   pick_type      pending_picks [$];
   load_beat_type cur_beat;
   int         gap_left;
   int         burst_left;
   int         errors;
   int         n_cand;
   int         n_taken;
   int         n_ends;
   int         cycles;
   int         stall_mode;
   int         gen_centers;

   logic [11:0] pool [0:7] = '{12'd0, 12'd1, 12'd2, 12'd3, 12'd7, 12'd100,
                               12'd2048, 12'd4095};

   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   function automatic logic [37:0] nearest_center_dist(logic [11:0] pt);
      logic [37:0] best;
      longint      sum;
      longint      diff;
      int          nd;
      best = DIST_MAX;
      nd = (dims_reg > 64) ? 64 : dims_reg;
      for (int c = 0; c < n_centers; c++) begin
         sum = 0;
         for (int d = 0; d < nd; d++) begin
            diff = longint'(coord_mem[pt][d]) - longint'(coord_mem[center_pts[c]][d]);
            sum += diff * diff;
         end
         if (sum > longint'(DIST_MAX)) sum = longint'(DIST_MAX);
         if (sum < longint'(best)) best = sum[37:0];
      end
      return best;
   endfunction

   function automatic void apply_beat(load_beat_type b);
      pick_type     p;
      logic [37:0]  dy;
      logic [101:0] lhs;
      logic [101:0] rhs;
      int           lim;
      case (b.kind)
         REQ_WRITE_COORD: coord_mem[b.pt][b.dim] = b.coord;
         REQ_APPEND: begin
            if (n_centers < MAX_CENTERS) begin
               center_pts[n_centers] = b.pt;
               n_centers++;
               chain_steps = 0;
            end
         end
         REQ_CLEAR: begin
            n_centers = 0;
            chain_steps = 0;
         end
         default: begin
            dy = nearest_center_dist(b.pt);
            lhs = {32'd0, 70'(dy) * 70'(chain_q)} << 32;
            rhs = 102'(chain_dist) * 102'(b.q) * 102'(b.u);
            p.acc = (chain_steps == 0 || chain_dist == 0 || b.q == 0) ? 1'b1 : (lhs > rhs);
            if (p.acc) begin
               chain_idx = b.pt;
               chain_dist = dy;
               chain_q = b.q;
            end
            lim = (chain_len_reg == 0) ? 1 : chain_len_reg;
            chain_steps++;
            p.last = (chain_steps >= lim);
            if (p.last) chain_steps = 0;
            p.idx = chain_idx;
            p.dsq = chain_dist;
            pending_picks = {pending_picks, p};
         end
      endcase
   endfunction

   function automatic load_beat_type mk(req_kind_type k, logic [11:0] pt, logic [5:0] dim,
                                        logic [15:0] cv, logic [31:0] q, logic [31:0] u);
      load_beat_type b;
      b.kind = k; b.pt = pt; b.dim = dim; b.coord = cv; b.q = q; b.u = u;
      return b;
   endfunction

   function automatic load_beat_type rand_beat();
      int r;
      logic [31:0] q;
      logic [11:0] pt;
      r = $urandom_range(0, 99);
      q = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom;
      pt = pool[$urandom_range(0, 7)];
      if (r < 8 && gen_centers < 6) begin
         gen_centers++;
         return mk(REQ_APPEND, pt, 6'($urandom), 16'($urandom), $urandom, $urandom);
      end
      if (r < 11) begin
         gen_centers = 0;
         return mk(REQ_CLEAR, 12'($urandom), 6'($urandom), 16'($urandom), $urandom,
                   $urandom);
      end
      if (r < 24)
         return mk(REQ_WRITE_COORD, pt, 6'($urandom_range(0, FILL_DIMS - 1)),
                   16'($urandom), $urandom, $urandom);
      return mk(REQ_CANDIDATE, pt, 6'($urandom), 16'($urandom), q, $urandom);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
         burst_left = 4;
      end else begin
         if (req_tvalid && req_tready) apply_beat(cur_beat);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (beat_q.size() > 0) begin
               cur_beat = beat_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= cur_beat.kind;
               req_tdata <= {6'd0, cur_beat.u, cur_beat.q, cur_beat.coord, cur_beat.dim,
                             cur_beat.pt};
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pick_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (cycles % 700 == 0) stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
         if (rsp_tvalid && rsp_tready) begin
            if (pending_picks.size() == 0) begin
               $display("%0t: unexpected result beat idx=%0d dist=%0d", $time,
                        rsp_tdata[11:0], rsp_tdata[49:12]);
               errors++;
            end else begin
               e = pending_picks.pop_front();
               n_taken += e.acc;
               n_ends += e.last;
               if (rsp_tdata[11:0] !== e.idx) begin
                  $display("%0t: chosen_index exp %0d got %0d", $time, e.idx, rsp_tdata[11:0]);
                  errors++;
               end
               if (rsp_tdata[49:12] !== e.dsq) begin
                  $display("%0t: chosen_dist exp %0d got %0d", $time, e.dsq,
                           rsp_tdata[49:12]);
                  errors++;
               end
               if (rsp_tuser !== e.acc) begin
                  $display("%0t: accepted exp %0d got %0d", $time, e.acc, rsp_tuser);
                  errors++;
               end
               if (rsp_tlast !== e.last) begin
                  $display("%0t: chain_end exp %0d got %0d", $time, e.last, rsp_tlast);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, pending_picks.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic drain();
      wait (beat_q.size() == 0 && !req_tvalid && pending_picks.size() == 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [9:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_DIMS) dims_reg = val[6:0];
      else chain_len_reg = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic cand(logic [11:0] pt, logic [31:0] q, logic [31:0] u);
      beat_q = {beat_q, mk(REQ_CANDIDATE, pt, 6'd0, 16'd0, q, u)};
   endtask

   task automatic add_center(logic [11:0] pt);
      beat_q = {beat_q, mk(REQ_APPEND, pt, 6'd0, 16'd0, 32'd0, 32'd0)};
   endtask

   task automatic clear_centers();
      beat_q = {beat_q, mk(REQ_CLEAR, 12'd0, 6'd0, 16'd0, 32'd0, 32'd0)};
   endtask

   initial begin
      logic [15:0] v;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_DIMS;
      csr_wdata = '0;
      errors = 0; n_cand = 0; n_taken = 0; n_ends = 0; cycles = 0;
      stall_mode = 0; gen_centers = 0;
      n_centers = 0; chain_idx = 0; chain_dist = 0; chain_q = 0; chain_steps = 0;
      dims_reg = 1; chain_len_reg = 200;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // fill the used coordinates of the point pool, extremes on the outer points
      for (int p = 0; p < 8; p++)
         for (int d = 0; d < FILL_DIMS; d++) begin
            v = (p == 0) ? 16'h8000 : (p == 7) ? 16'h7fff : 16'($urandom);
            beat_q = {beat_q, mk(REQ_WRITE_COORD, pool[p], d[5:0], v, $urandom, $urandom)};
         end
      drain();

      // empty center list, then two centers, zero weight and extreme draws
      csr_write(CSR_DIMS, 10'd4);
      csr_write(CSR_CHAIN, 10'd5);
      cand(12'd1, 32'h8000_0000, 32'h1234_5678);
      cand(12'd2, 32'hffff_ffff, 32'hffff_ffff);
      add_center(12'd0);
      add_center(12'd4095);
      cand(12'd4095, 32'hffff_ffff, 32'd0);
      cand(12'd0, 32'd1, 32'hffff_ffff);
      cand(12'd3, 32'd0, 32'hffff_ffff);
      cand(12'd2, 32'h0000_0001, 32'd0);
      cand(12'd100, 32'hffff_ffff, 32'hffff_ffff);
      cand(12'd7, 32'h4000_0000, 32'h8000_0000);
      clear_centers();
      cand(12'd2048, 32'h7fff_ffff, 32'h0);
      add_center(12'd0);
      drain();

      // dims zero, chain length zero
      csr_write(CSR_DIMS, 10'd0);
      csr_write(CSR_CHAIN, 10'd0);
      cand(12'd4095, $urandom, $urandom);
      cand(12'd1, $urandom, $urandom);
      drain();

      // clamped dims with no centers, chain lowered mid-chain
      clear_centers();
      drain();
      csr_write(CSR_DIMS, 10'd127);
      csr_write(CSR_CHAIN, 10'd10);
      repeat (3) cand(pool[$urandom_range(0, 7)], $urandom, $urandom);
      drain();
      csr_write(CSR_CHAIN, 10'd2);
      cand(12'd4095, $urandom, $urandom);
      cand(12'd2, $urandom, $urandom);
      drain();

      // random phases over several register settings
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin csr_write(CSR_DIMS, 10'd6); csr_write(CSR_CHAIN, 10'd1023); end
            1: begin csr_write(CSR_DIMS, 10'd1); csr_write(CSR_CHAIN, 10'd1); end
            2: begin csr_write(CSR_DIMS, 10'd5); csr_write(CSR_CHAIN, 10'd7); end
            default: begin csr_write(CSR_DIMS, 10'd0); csr_write(CSR_CHAIN, 10'd3); end
         endcase
         gen_centers = 0;
         clear_centers();
         repeat (2) begin
            gen_centers++;
            add_center(pool[$urandom_range(0, 7)]);
         end
         repeat (8) beat_q = {beat_q, rand_beat()};
         drain();
      end

      drain();
      repeat (50) @(posedge clock);
      $display("covered %0d chain results, %0d took the candidate, %0d ended a chain",
               n_cand, n_taken, n_ends);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", errors);
         $display("Regression FAIL");
      end
      $finish;
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) n_cand++;

endmodule

### filelist.f
design/mkss_pkg.sv
design/mkss_smul.sv
design/mcmc_kmeans_seed_sampler.sv
dv/tb_mcmc_kmeans_seed_sampler.sv
